// File: rtl/core/h2rgb_pkg.sv
// Shared types, constants and the hue sector decode for the HSL to RGB converter.
`timescale 1ns / 1ps

package h2rgb_pkg;

   // Fixed-point constants (4.12 format)
   localparam logic [12:0] FRAC_ONE   = 13'h1000;
   localparam logic [12:0] FRAC_MASK  = 13'h0FFF;
   localparam logic [12:0] HALF_SPLIT = 13'h0801;
   localparam logic [31:0] ROUND_ADD  = 32'h0000_0800;
   localparam logic [15:0] TURN       = 16'd24576;
   localparam logic [7:0]  BYTE_MAX   = 8'hFF;

   // Channel index codes
   typedef logic [1:0] chan_idx_type;
   localparam chan_idx_type CH_RED   = 2'd0;
   localparam chan_idx_type CH_GREEN = 2'd1;
   localparam chan_idx_type CH_BLUE  = 2'd2;

   // Which channel gets the maximum, the minimum and the interpolated value
   typedef struct packed {
      chan_idx_type hi;
      chan_idx_type mid;
      chan_idx_type lo;
   } chan_map_type;

   // Sector decode from the top three hue bits; the sector is (top + 1) mod 6
   function automatic chan_map_type sector_map(input logic [2:0] hue_top);
      chan_map_type m;
      case (hue_top)
         3'd5: begin                              // sector 0
            m.hi = CH_RED;   m.lo = CH_GREEN; m.mid = CH_BLUE;
         end
         3'd0, 3'd6: begin                        // sector 1
            m.hi = CH_RED;   m.mid = CH_GREEN; m.lo = CH_BLUE;
         end
         3'd1, 3'd7: begin                        // sector 2
            m.hi = CH_GREEN; m.lo = CH_BLUE;  m.mid = CH_RED;
         end
         3'd2: begin                              // sector 3
            m.hi = CH_GREEN; m.mid = CH_BLUE; m.lo = CH_RED;
         end
         3'd3: begin                              // sector 4
            m.hi = CH_BLUE;  m.lo = CH_RED;   m.mid = CH_GREEN;
         end
         default: begin                           // sector 5
            m.hi = CH_BLUE;  m.mid = CH_RED;  m.lo = CH_GREEN;
         end
      endcase
      return m;
   endfunction

   // Pick the value that belongs to one output channel
   function automatic logic [31:0] pick_chan(input chan_map_type m,
                                             input chan_idx_type ch,
                                             input logic [31:0] v_hi,
                                             input logic [31:0] v_mid,
                                             input logic [31:0] v_lo);
      logic [31:0] v;
      if (m.hi == ch) begin
         v = v_hi;
      end else if (m.lo == ch) begin
         v = v_lo;
      end else begin
         v = v_mid;
      end
      return v;
   endfunction

endpackage

// File: rtl/core/h2rgb_req_if.sv
// Request channel: one HSL colour and its intensity.
`timescale 1ns / 1ps

interface h2rgb_req_if;
   logic        valid;
   logic        ready;
   logic [14:0] hue;
   logic [12:0] lightness;
   logic [12:0] saturation;
   logic [7:0]  intensity;

   modport source (output valid, hue, lightness, saturation, intensity, input ready);
   modport sink   (input valid, hue, lightness, saturation, intensity, output ready);
endinterface

// File: rtl/core/h2rgb_rsp_if.sv
// Response channel: one 8-bit RGB triple.
`timescale 1ns / 1ps

interface h2rgb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: rtl/core/h2rgb_sat_round.sv
// Rounds one 20.12 channel word to an integer byte, saturating at 255.
`timescale 1ns / 1ps

module h2rgb_sat_round (
   input  logic [31:0] chan_word,
   output logic [7:0]  chan_byte
);

   logic [31:0] rounded;

   // Round half up, wrap at 32 bits, clamp anything of 256 or more
   always_comb begin
      rounded = chan_word + h2rgb_pkg::ROUND_ADD;
      if (|rounded[31:20]) begin
         chan_byte = h2rgb_pkg::BYTE_MAX;
      end else begin
         chan_byte = rounded[19:12];
      end
   end

endmodule

// File: rtl/core/hsl_to_rgb_scaled.sv
// Top level: pipelined HSL (4.12) to scaled 8-bit RGB converter.
`timescale 1ns / 1ps

// Converts hue/lightness/saturation to an RGB triple scaled by intensity.
// Seven register stages; a request enters every clock unless the pipe
// is stalled, one response per request, in order. Each stage moves only
// when the stage after it is empty or moving, so a stall on the response
// side holds the pipe in place and bubbles are squeezed out; the request
// side keeps accepting until the pipe fills. Throughput is one pixel per
// clock while the response side is ready; the depth is set by the multiply
// chain (lightness product, intensity product, interpolation product).

module hsl_to_rgb_scaled (
   input  logic               clock,
   input  logic               reset,
   h2rgb_req_if.sink          req_chan,
   h2rgb_rsp_if.source        rsp_chan
);

   localparam int NSTG = 7;

   // Stage valids and load enables
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG:0]   en;

   // Stage 1: sector decode, hue offset, lightness products
   h2rgb_pkg::chan_map_type s1_map_ff, s1_map_in;
   logic [14:0]        s1_hmod_ff, s1_hmod_in;
   logic signed [27:0] s1_prod_ff, s1_prod_in;
   logic [21:0]        s1_ls2_ff, s1_ls2_in;
   logic               s1_low_ff, s1_low_in;
   logic [12:0]        s1_sat_ff;
   logic [7:0]         s1_scl_ff;
   logic [15:0]        hue_sum;
   logic signed [13:0] sat_comp;

   // Stage 2: truncated quotient and operand, in-sector distance
   h2rgb_pkg::chan_map_type s2_map_ff;
   logic signed [16:0] s2_opnd_ff, s2_opnd_in;
   logic [12:0]        s2_off_ff, s2_off_in;
   logic [21:0]        s2_ls2_ff;
   logic               s2_low_ff;
   logic [7:0]         s2_scl_ff;
   logic signed [27:0] prod_adj;
   logic signed [15:0] part;
   logic [12:0]        hue_dist;

   // Stage 3: intensity product
   h2rgb_pkg::chan_map_type s3_map_ff;
   logic signed [25:0] s3_sum_ff, s3_sum_in;
   logic [12:0]        s3_off_ff;
   logic [21:0]        s3_ls2_ff;
   logic               s3_low_ff;

   // Stage 4: max and min channel words and their difference
   h2rgb_pkg::chan_map_type s4_map_ff;
   logic [31:0]        s4_hi_ff, s4_hi_in;
   logic [31:0]        s4_lo_ff, s4_lo_in;
   logic [31:0]        s4_diff_ff, s4_diff_in;
   logic [12:0]        s4_off_ff;
   logic [31:0]        sum_ext;
   logic [31:0]        rest;

   // Stage 5: interpolation product
   h2rgb_pkg::chan_map_type s5_map_ff;
   logic [31:0]        s5_mprod_ff, s5_mprod_in;
   logic [31:0]        s5_hi_ff;
   logic [31:0]        s5_lo_ff;

   // Stage 6: middle channel
   h2rgb_pkg::chan_map_type s6_map_ff;
   logic [31:0]        s6_mid_ff, s6_mid_in;
   logic [31:0]        s6_hi_ff;
   logic [31:0]        s6_lo_ff;

   // Stage 7: routed, rounded bytes
   logic [31:0]        red_word, green_word, blue_word;
   logic [7:0]         red_byte, green_byte, blue_byte;
   logic [7:0]         s7_red_ff, s7_green_ff, s7_blue_ff;

   // Load enables: a stage loads when empty or when the next one loads
   always_comb begin
      en[NSTG] = rsp_chan.ready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   // No request is taken while reset is held
   assign req_chan.ready = en[0] && !reset;

   always_comb begin
      vld_in[0] = req_chan.valid;
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // Stage 1 logic
   always_comb begin
      s1_map_in = h2rgb_pkg::sector_map(req_chan.hue[14:12]);
      hue_sum   = {1'b0, req_chan.hue} + {3'b000, h2rgb_pkg::FRAC_ONE};
      if (hue_sum >= h2rgb_pkg::TURN) begin
         s1_hmod_in = 15'(hue_sum - h2rgb_pkg::TURN);
      end else begin
         s1_hmod_in = hue_sum[14:0];
      end
      sat_comp   = $signed({1'b0, h2rgb_pkg::FRAC_ONE}) - $signed({1'b0, req_chan.saturation});
      s1_prod_in = 28'($signed({1'b0, req_chan.lightness}) * sat_comp);
      s1_ls2_in  = {21'(req_chan.lightness * req_chan.intensity), 1'b0};
      s1_low_in  = req_chan.lightness < h2rgb_pkg::HALF_SPLIT;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_map_ff  <= s1_map_in;
         s1_hmod_ff <= s1_hmod_in;
         s1_prod_ff <= s1_prod_in;
         s1_ls2_ff  <= s1_ls2_in;
         s1_low_ff  <= s1_low_in;
         s1_sat_ff  <= req_chan.saturation;
         s1_scl_ff  <= req_chan.intensity;
      end
   end

   // Stage 2 logic: divide by 4096 toward zero, distance to sector middle
   always_comb begin
      if (s1_prod_ff < 0) begin
         prod_adj = s1_prod_ff + $signed({15'd0, h2rgb_pkg::FRAC_MASK});
      end else begin
         prod_adj = s1_prod_ff;
      end
      part = prod_adj[27:12];
      if (s1_low_ff) begin
         s2_opnd_in = 17'(part);
      end else begin
         s2_opnd_in = 17'(part) + $signed({4'd0, s1_sat_ff});
      end
      hue_dist = 13'(s1_hmod_ff - {s1_map_ff.hi, 13'd0});
      if (hue_dist >= h2rgb_pkg::FRAC_ONE) begin
         s2_off_in = hue_dist - h2rgb_pkg::FRAC_ONE;
      end else begin
         s2_off_in = h2rgb_pkg::FRAC_ONE - hue_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_map_ff  <= s1_map_ff;
         s2_opnd_ff <= s2_opnd_in;
         s2_off_ff  <= s2_off_in;
         s2_ls2_ff  <= s1_ls2_ff;
         s2_low_ff  <= s1_low_ff;
         s2_scl_ff  <= s1_scl_ff;
      end
   end

   // Stage 3 logic: scale by intensity
   assign s3_sum_in = 26'(s2_opnd_ff * $signed({1'b0, s2_scl_ff}));

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_map_ff <= s2_map_ff;
         s3_sum_ff <= s3_sum_in;
         s3_off_ff <= s2_off_ff;
         s3_ls2_ff <= s2_ls2_ff;
         s3_low_ff <= s2_low_ff;
      end
   end

   // Stage 4 logic: max/min words, wrapping at 32 bits
   always_comb begin
      sum_ext = {{6{s3_sum_ff[25]}}, s3_sum_ff};
      rest    = {10'd0, s3_ls2_ff} - sum_ext;
      if (s3_low_ff) begin
         s4_lo_in = sum_ext;
         s4_hi_in = rest;
      end else begin
         s4_hi_in = sum_ext;
         s4_lo_in = rest;
      end
      s4_diff_in = s4_hi_in - s4_lo_in;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_map_ff  <= s3_map_ff;
         s4_hi_ff   <= s4_hi_in;
         s4_lo_ff   <= s4_lo_in;
         s4_diff_ff <= s4_diff_in;
         s4_off_ff  <= s3_off_ff;
      end
   end

   // Stage 5 logic: interpolation product, low word kept
   assign s5_mprod_in = 32'(s4_diff_ff * {19'd0, s4_off_ff});

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_map_ff   <= s4_map_ff;
         s5_mprod_ff <= s5_mprod_in;
         s5_hi_ff    <= s4_hi_ff;
         s5_lo_ff    <= s4_lo_ff;
      end
   end

   // Stage 6 logic: middle channel from the min word
   assign s6_mid_in = {12'd0, s5_mprod_ff[31:12]} + s5_lo_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_map_ff <= s5_map_ff;
         s6_mid_ff <= s6_mid_in;
         s6_hi_ff  <= s5_hi_ff;
         s6_lo_ff  <= s5_lo_ff;
      end
   end

   // Stage 7 logic: route to red/green/blue, then round and saturate
   always_comb begin
      red_word   = h2rgb_pkg::pick_chan(s6_map_ff, h2rgb_pkg::CH_RED,
                                        s6_hi_ff, s6_mid_ff, s6_lo_ff);
      green_word = h2rgb_pkg::pick_chan(s6_map_ff, h2rgb_pkg::CH_GREEN,
                                        s6_hi_ff, s6_mid_ff, s6_lo_ff);
      blue_word  = h2rgb_pkg::pick_chan(s6_map_ff, h2rgb_pkg::CH_BLUE,
                                        s6_hi_ff, s6_mid_ff, s6_lo_ff);
   end

   h2rgb_sat_round u_round_red (
      .chan_word (red_word),
      .chan_byte (red_byte)
   );

   h2rgb_sat_round u_round_green (
      .chan_word (green_word),
      .chan_byte (green_byte)
   );

   h2rgb_sat_round u_round_blue (
      .chan_word (blue_word),
      .chan_byte (blue_byte)
   );

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_red_ff   <= red_byte;
         s7_green_ff <= green_byte;
         s7_blue_ff  <= blue_byte;
      end
   end

   // Response outputs
   assign rsp_chan.valid = vld_ff[NSTG-1];
   assign rsp_chan.red   = s7_red_ff;
   assign rsp_chan.green = s7_green_ff;
   assign rsp_chan.blue  = s7_blue_ff;

endmodule

// File: tb/tb_hsl_to_rgb_scaled.sv
// Self-checking testbench for the pipelined HSL to scaled RGB converter.
`timescale 1ns / 1ps

module tb_hsl_to_rgb_scaled;

   // Fixed-point constants used by the color predictor
   localparam int          ONE_FIX    = 4096;
   localparam int          SPLIT_LIG  = 2049;
   localparam logic [31:0] HUE_TURN   = 32'd24576;
   localparam logic [31:0] ROUND_HALF = 32'h800;
   localparam int          ITEM_COUNT = 1750;
   localparam int          DRAIN_MAX  = 4000;

   typedef struct packed {
      logic [14:0] hue;
      logic [12:0] lightness;
      logic [12:0] saturation;
      logic [7:0]  intensity;
   } hsl_pixel_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_pixel_type;

   // Predicts one RGB triple per request and checks responses in order
   class pixel_scoreboard;
      rgb_pixel_type pending_rgb[$];
      int            failures = 0;

      function logic [7:0] round_byte(logic [31:0] v);
         logic [31:0] r;
         r = (v + ROUND_HALF) >> 12;
         return (r >= 32'd256) ? 8'hFF : r[7:0];
      endfunction

      function rgb_pixel_type convert_hsl(hsl_pixel_type px);
         int unsigned   sector, hi_ch, lo_ch, mid_ch;
         int            lig, sat, scl, part, blend;
         logic [31:0]   chan [3];
         logic [31:0]   angle, span, diff, prod;
         rgb_pixel_type rgb;
         sector = px.hue[14:12];
         sector = (sector + 1) % 6;
         hi_ch  = sector / 2;
         if (sector % 2 == 1) begin
            mid_ch = (hi_ch + 1) % 3;
            lo_ch  = (hi_ch + 2) % 3;
         end else begin
            lo_ch  = (hi_ch + 1) % 3;
            mid_ch = (hi_ch + 2) % 3;
         end
         lig = px.lightness;
         sat = px.saturation;
         scl = px.intensity;
         // signed product, division truncates toward zero
         part = (lig * (ONE_FIX - sat)) / ONE_FIX;
         if (lig < SPLIT_LIG) begin
            blend        = part * scl;
            chan[lo_ch]  = blend;
            chan[hi_ch]  = 2 * lig * scl - blend;
         end else begin
            blend        = (part + sat) * scl;
            chan[hi_ch]  = blend;
            chan[lo_ch]  = 2 * lig * scl - blend;
         end
         // distance within the sector drives the middle channel
         angle = 32'(px.hue) + 32'd4096;
         angle = angle % HUE_TURN - (32'(hi_ch) << 13);
         span  = (angle >= 32'd4096) ? angle - 32'd4096 : 32'd4096 - angle;
         diff  = chan[hi_ch] - chan[lo_ch];
         prod  = diff * span;
         chan[mid_ch] = (prod >> 12) + chan[lo_ch];
         rgb.red   = round_byte(chan[h2rgb_pkg::CH_RED]);
         rgb.green = round_byte(chan[h2rgb_pkg::CH_GREEN]);
         rgb.blue  = round_byte(chan[h2rgb_pkg::CH_BLUE]);
         return rgb;
      endfunction

      function void note_request(hsl_pixel_type px);
         pending_rgb.push_back(convert_hsl(px));
      endfunction

      function void check_response(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         rgb_pixel_type want;
         if (pending_rgb.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response rgb=%0d,%0d,%0d", r, g, b);
            return;
         end
         want = pending_rgb.pop_front();
         if (want.red !== r || want.green !== g || want.blue !== b) begin
            failures++;
            if (failures <= 10)
               $display("rgb mismatch: expected %0d,%0d,%0d got %0d,%0d,%0d",
                        want.red, want.green, want.blue, r, g, b);
         end
      endfunction

      function int outstanding();
         return pending_rgb.size();
      endfunction

      function void close_out();
         if (pending_rgb.size() != 0) begin
            failures++;
            $display("%0d expected responses never arrived", pending_rgb.size());
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   draining = 1'b0;

   pixel_scoreboard board;

   h2rgb_req_if req_bus ();
   h2rgb_rsp_if rsp_bus ();

   hsl_to_rgb_scaled dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offer one request and hold it until the block takes it
   task automatic send_pixel(input logic [14:0] h, input logic [12:0] l,
                             input logic [12:0] s, input logic [7:0] k);
      hsl_pixel_type px;
      px.hue        = h;
      px.lightness  = l;
      px.saturation = s;
      px.intensity  = k;
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.hue        <= h;
      req_bus.lightness  <= l;
      req_bus.saturation <= s;
      req_bus.intensity  <= k;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(px);
   endtask

   // Drop valid for a caller-chosen time with junk on the payload
   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_bus.valid      <= 1'b0;
      req_bus.hue        <= 15'($urandom);
      req_bus.lightness  <= 13'($urandom);
      req_bus.saturation <= 13'($urandom);
      req_bus.intensity  <= 8'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Mostly in-range colors, plus corners, the lightness split and overrange operands
   function automatic hsl_pixel_type random_pixel();
      hsl_pixel_type px;
      int            pick;
      pick = $urandom_range(0, 9);
      px.hue        = 15'($urandom_range(0, 24575));
      px.lightness  = 13'($urandom_range(0, 4096));
      px.saturation = 13'($urandom_range(0, 4096));
      px.intensity  = 8'($urandom_range(0, 255));
      case (pick)
         6: begin
            px.hue        = 15'($urandom);
            px.lightness  = 13'($urandom);
            px.saturation = 13'($urandom);
            px.intensity  = 8'($urandom);
         end
         7: begin
            case ($urandom_range(0, 2))
               0: px.hue = 15'($urandom_range(0, 7) * 4096);
               1: px.hue = 15'($urandom_range(0, 7) * 4096 + 1);
               default: px.hue = 15'($urandom_range(0, 7) * 4096 + 4095);
            endcase
            case ($urandom_range(0, 3))
               0: px.lightness = 13'd0;
               1: px.lightness = 13'd2048;
               2: px.lightness = 13'd2049;
               default: px.lightness = 13'd4096;
            endcase
            px.saturation = $urandom_range(0, 1) ? 13'd4096 : 13'd0;
            px.intensity  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         end
         8: px.lightness = 13'($urandom_range(2040, 2060));
         9: begin
            px.hue        = 15'($urandom_range(0, 32767));
            px.lightness  = 13'($urandom_range(4097, 8191));
            px.saturation = 13'($urandom_range(0, 8191));
         end
         default: ;
      endcase
      return px;
   endfunction

   // Response side: stall patterns, long hold-offs, always ready once draining
   initial begin : receiver
      int  seg, len, mode, c;
      bit  take;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      seg = 0;
      forever begin
         len  = $urandom_range(20, 120);
         mode = $urandom_range(0, 3);
         // long hold-off so the pipe fills and back-pressures requests
         if (seg % 12 == 3) begin
            mode = 4;
            len  = $urandom_range(60, 100);
         end
         for (c = 0; c < len; c++) begin
            case (mode)
               0: take = 1'b1;
               1: take = $urandom_range(0, 1);
               2: take = ($urandom_range(0, 3) == 0);
               3: take = (c % 3 != 2);
               default: take = 1'b0;
            endcase
            @(negedge clock);
            rsp_bus.ready <= draining ? 1'b1 : take;
         end
         seg++;
      end
   end

   // Compare every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_response(rsp_bus.red, rsp_bus.green, rsp_bus.blue);
   end

   // Run limit
   initial begin
      #6_000_000;
      $display("[hsl_to_rgb_scaled] ERROR");
      $finish;
   end

   // Main stimulus
   initial begin : stimulus
      hsl_pixel_type px;
      int            sent, burst, n, waited;
      board = new();
      req_bus.valid      = 1'b0;
      req_bus.hue        = '0;
      req_bus.lightness  = '0;
      req_bus.saturation = '0;
      req_bus.intensity  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: black, white, every sector edge, turn wrap, split, overrange
      send_pixel(15'd0,     13'd0,    13'd0,    8'd0);
      send_pixel(15'd0,     13'd4096, 13'd0,    8'd255);
      send_pixel(15'd0,     13'd2048, 13'd4096, 8'd255);
      send_pixel(15'd4095,  13'd2048, 13'd4096, 8'd255);
      send_pixel(15'd4096,  13'd2048, 13'd4096, 8'd255);
      send_pixel(15'd8192,  13'd2048, 13'd4096, 8'd255);
      send_pixel(15'd12288, 13'd2048, 13'd4096, 8'd255);
      send_pixel(15'd16384, 13'd2048, 13'd4096, 8'd255);
      send_pixel(15'd20480, 13'd2048, 13'd4096, 8'd255);
      send_pixel(15'd24575, 13'd2048, 13'd4096, 8'd255);
      send_pixel(15'd24576, 13'd2048, 13'd4096, 8'd255);
      send_pixel(15'd28672, 13'd2049, 13'd4096, 8'd255);
      send_pixel(15'd32767, 13'd2049, 13'd4096, 8'd255);
      send_pixel(15'd2048,  13'd2048, 13'd2048, 8'd128);
      send_pixel(15'd2048,  13'd2049, 13'd2048, 8'd128);
      send_pixel(15'd6000,  13'd4096, 13'd4096, 8'd255);
      send_pixel(15'd10000, 13'd1024, 13'd4096, 8'd1);
      send_pixel(15'd14000, 13'd8191, 13'd0,    8'd255);
      send_pixel(15'd18000, 13'd8191, 13'd8191, 8'd255);
      send_pixel(15'd22000, 13'd3000, 13'd8191, 8'd200);
      send_pixel(15'd3000,  13'd1000, 13'd6000, 8'd77);
      send_pixel(15'd12345, 13'd4096, 13'd2048, 8'd0);
      send_pixel(15'd32767, 13'd8191, 13'd8191, 8'd255);
      idle_sender(3);

      // random bursts separated by random gaps
      sent = 0;
      while (sent < ITEM_COUNT) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(1, 30);
         for (n = 0; n < burst && sent < ITEM_COUNT; n++) begin
            px = random_pixel();
            send_pixel(px.hue, px.lightness, px.saturation, px.intensity);
            sent++;
         end
         idle_sender($urandom_range(1, 8));
      end

      // drain: wait for outstanding responses, then let the pipe settle
      draining = 1'b1;
      waited = 0;
      while (board.outstanding() > 0 && waited < DRAIN_MAX) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);
      board.close_out();
      if (board.failures == 0)
         $display("[hsl_to_rgb_scaled] OK");
      else
         $display("[hsl_to_rgb_scaled] ERROR");
      $finish;
   end

endmodule
